@@ design/sstg_pkg.sv @@
// ---------------------------------------------------------------------------
// sstg_pkg
// shared types, codes and constants of the step sequencer tempo grid
// ---------------------------------------------------------------------------
`default_nettype none

package sstg_pkg;

   // default grid geometry
   localparam int COLUMNS_DEF = 16;
   localparam int ROWS_DEF    = 9;

   // field and state widths
   localparam int ACTION_W  = 3;
   localparam int CELL_W    = 4;
   localparam int TEMPO_W   = 10;
   localparam int ELAPSED_W = 16;
   localparam int STEP_W    = 4;
   localparam int MASK_W    = 9;
   localparam int PROD_W    = ELAPSED_W + 1 + TEMPO_W;

   // reciprocal multiply for tempo / 10 and tempo / 25
   localparam int RECIP_W     = 11;
   localparam int QPROD_W     = TEMPO_W + RECIP_W;
   localparam int RECIP10     = 205;
   localparam int RECIP10_SH  = 11;
   localparam int RECIP25     = 1311;
   localparam int RECIP25_SH  = 15;

   // constants and reset values
   localparam int BEAT_MS     = 60000;
   localparam int TEMPO_RESET = 120;
   localparam int MIN_RESET   = 40;
   localparam int MAX_RESET   = 240;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_TOGGLE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CLICK  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SLOWER = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_FASTER = 3'd4;

   // csr register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TEMPO = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TEMPO = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_TICK_MUL,
      S_TICK_CMP,
      S_STEP_OUT,
      S_SLOW_MUL,
      S_SLOW_APPLY,
      S_FAST_MUL,
      S_FAST_APPLY,
      S_NUDGE_MUL,
      S_NUDGE_APPLY,
      S_TOG_WRITE
   } state_type;

   typedef struct packed {
      logic load_item;
      logic elapsed_inc;
      logic prod_load;
      logic step_begin;
      logic load_rsp;
      logic tog_read;
      logic tog_write;
      logic click_flip;
      logic quot_load;
      logic quot_div10;
      logic tempo_down;
      logic tempo_up;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                toggle_ok;
      logic                step_due;
      logic                hold_slower;
      logic                hold_faster;
      logic                rsp_busy;
   } status_type;

endpackage

`default_nettype wire

@@ design/step_sequencer_tempo_grid.sv @@
// ---------------------------------------------------------------------------
// step_sequencer_tempo_grid
// note grid step sequencer with tempo control and metronome click
// ---------------------------------------------------------------------------
//
//   channel  ports              direction  handshake
//   req      req_action ...     in         req_valid / req_ready
//   rsp      rsp_step_column .. out        rsp_valid / rsp_ready
//   csr      csr_index, wdata   in         csr_write, no wait
//
// one item at a time; req_ready is high only while the sequencer is idle
// the sequencer steps each item through its states one stage a cycle, but for
//   waits at the output: a tick runs multiply and compare, and when a step is
//   due a grid memory read and output, then a quotient and tempo update for
//   each held tempo flag; a toggle reads and writes grid memory
// a step waits in its output stage only while a previous step is unread
// synchronous reset clears the grid through per-column valid bits at once
// ---------------------------------------------------------------------------
`default_nettype none

module step_sequencer_tempo_grid import sstg_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // item input
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [CELL_W-1:0]    req_cell_column,
   input  wire logic [CELL_W-1:0]    req_cell_row,
   input  wire logic                 req_hold_slower,
   input  wire logic                 req_hold_faster,
   // step output
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STEP_W-1:0]         rsp_step_column,
   output logic [MASK_W-1:0]         rsp_note_mask,
   output logic                      rsp_click,
   // tempo limits
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TEMPO_W-1:0]   csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // controller: decodes the item and issues the datapath commands of each state
   sstg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: grid memory, tempo math, step timer, output register
   sstg_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_cell_column (req_cell_column),
      .req_cell_row    (req_cell_row),
      .req_hold_slower (req_hold_slower),
      .req_hold_faster (req_hold_faster),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_step_column (rsp_step_column),
      .rsp_note_mask   (rsp_note_mask),
      .rsp_click       (rsp_click)
   );

endmodule

`default_nettype wire

@@ design/sstg_ctrl.sv @@
// ---------------------------------------------------------------------------
// sstg_ctrl
// sequencing state machine: decodes each item and steps the datapath
// ---------------------------------------------------------------------------
`default_nettype none

module sstg_ctrl import sstg_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.action)
               ACT_TICK: begin
                  cmd.elapsed_inc = 1'b1;
                  state_in        = S_TICK_MUL;
               end
               ACT_TOGGLE: begin
                  if (status.toggle_ok) begin
                     cmd.tog_read = 1'b1;
                     state_in     = S_TOG_WRITE;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               ACT_CLICK: begin
                  cmd.click_flip = 1'b1;
                  state_in       = S_IDLE;
               end
               ACT_SLOWER, ACT_FASTER: begin
                  state_in = S_NUDGE_MUL;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_TICK_MUL: begin
            cmd.prod_load = 1'b1;
            state_in      = S_TICK_CMP;
         end
         S_TICK_CMP: begin
            if (status.step_due) begin
               cmd.step_begin = 1'b1;
               state_in       = S_STEP_OUT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_STEP_OUT: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               if (status.hold_slower) begin
                  state_in = S_SLOW_MUL;
               end else if (status.hold_faster) begin
                  state_in = S_FAST_MUL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SLOW_MUL: begin
            cmd.quot_load  = 1'b1;
            cmd.quot_div10 = 1'b1;
            state_in       = S_SLOW_APPLY;
         end
         S_SLOW_APPLY: begin
            cmd.tempo_down = 1'b1;
            state_in       = status.hold_faster ? S_FAST_MUL : S_IDLE;
         end
         S_FAST_MUL: begin
            cmd.quot_load  = 1'b1;
            cmd.quot_div10 = 1'b1;
            state_in       = S_FAST_APPLY;
         end
         S_FAST_APPLY: begin
            cmd.tempo_up = 1'b1;
            state_in     = S_IDLE;
         end
         S_NUDGE_MUL: begin
            cmd.quot_load = 1'b1;
            state_in      = S_NUDGE_APPLY;
         end
         S_NUDGE_APPLY: begin
            if (status.action == ACT_SLOWER) begin
               cmd.tempo_down = 1'b1;
            end else begin
               cmd.tempo_up = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_TOG_WRITE: begin
            cmd.tog_write = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // a finished item is never pushed over one still waiting at the output
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !status.rsp_busy)
      else $error("result loaded while previous result still pending");

   // tempo is adjusted only right after its quotient was formed
   assert property (@(posedge clock) disable iff (reset)
      (cmd.tempo_down || cmd.tempo_up) |-> $past(cmd.quot_load))
      else $error("tempo applied without fresh quotient");

endmodule

`default_nettype wire

@@ design/sstg_datapath.sv @@
// ---------------------------------------------------------------------------
// sstg_datapath
// grid memory, tempo arithmetic, step timing and result register
// ---------------------------------------------------------------------------
`default_nettype none

module sstg_datapath import sstg_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output status_type                status,
   input  wire logic [ACTION_W-1:0]  req_action,
   input  wire logic [CELL_W-1:0]    req_cell_column,
   input  wire logic [CELL_W-1:0]    req_cell_row,
   input  wire logic                 req_hold_slower,
   input  wire logic                 req_hold_faster,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TEMPO_W-1:0]   csr_wdata,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STEP_W-1:0]         rsp_step_column,
   output logic [MASK_W-1:0]         rsp_note_mask,
   output logic                      rsp_click
);

   localparam int ColW = $clog2(COLUMNS);

   // latched item
   logic [ACTION_W-1:0] item_action_ff;
   logic [CELL_W-1:0]   item_col_ff;
   logic [CELL_W-1:0]   item_row_ff;
   logic                item_slower_ff;
   logic                item_faster_ff;

   // sequencer state
   logic [TEMPO_W-1:0]   min_tempo_ff, max_tempo_ff;
   logic [TEMPO_W-1:0]   tempo_ff, tempo_in;
   logic                 click_ff;
   logic [ColW-1:0]      play_col_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [TEMPO_W-1:0]   quot_ff;

   // grid memory with per-column valid bits
   logic [ROWS-1:0]    grid_ff [COLUMNS];
   logic [COLUMNS-1:0] grid_vld_ff;
   logic [ROWS-1:0]    rd_data_ff;
   logic               rd_vld_ff;
   logic [ColW-1:0]    rd_addr;
   logic [ColW-1:0]    tog_addr;
   logic [ROWS-1:0]    rd_eff;

   logic               rsp_valid_ff;
   logic [STEP_W-1:0]  rsp_col_ff;
   logic [MASK_W-1:0]  rsp_mask_ff;
   logic               rsp_click_ff;

   logic [ELAPSED_W:0]    elapsed_p1;
   logic [RECIP_W-1:0]    recip;
   logic [QPROD_W-1:0]    qprod;
   logic [TEMPO_W-1:0]    quot_in;
   logic [TEMPO_W-1:0]    tempo_dec;
   logic [TEMPO_W:0]      tempo_inc;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_action_ff <= req_action;
         item_col_ff    <= req_cell_column;
         item_row_ff    <= req_cell_row;
         item_slower_ff <= req_hold_slower;
         item_faster_ff <= req_hold_faster;
      end
   end

   assign tog_addr = ColW'(item_col_ff);
   assign rd_addr  = cmd.tog_read ? tog_addr : play_col_ff;
   assign rd_eff   = rd_vld_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.tog_read || cmd.step_begin) begin
         rd_data_ff <= grid_ff[rd_addr];
         rd_vld_ff  <= grid_vld_ff[rd_addr];
      end
      if (cmd.tog_write) begin
         grid_ff[tog_addr] <= rd_eff ^ (ROWS'(1) << item_row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_vld_ff <= '0;
      end else if (cmd.tog_write) begin
         grid_vld_ff[tog_addr] <= 1'b1;
      end
   end

   // tempo quotient by reciprocal multiply
   assign recip   = cmd.quot_div10 ? RECIP_W'(RECIP10) : RECIP_W'(RECIP25);
   assign qprod   = QPROD_W'(tempo_ff) * QPROD_W'(recip);
   assign quot_in = cmd.quot_div10 ? TEMPO_W'(qprod >> RECIP10_SH)
                                   : TEMPO_W'(qprod >> RECIP25_SH);

   always_ff @(posedge clock) begin
      if (cmd.quot_load) begin
         quot_ff <= quot_in;
      end
   end

   assign tempo_dec = tempo_ff - quot_ff;
   assign tempo_inc = {1'b0, tempo_ff} + {1'b0, quot_ff};

   always_comb begin
      tempo_in = tempo_ff;
      if (cmd.tempo_down) begin
         tempo_in = (tempo_dec < min_tempo_ff) ? min_tempo_ff : tempo_dec;
      end else if (cmd.tempo_up) begin
         tempo_in = (tempo_inc > {1'b0, max_tempo_ff}) ? max_tempo_ff
                                                      : tempo_inc[TEMPO_W-1:0];
      end
   end

   // step timing: due once (elapsed + 1) * tempo passes one minute in ms
   assign elapsed_p1 = {1'b0, elapsed_ff} + (ELAPSED_W+1)'(1);

   always_ff @(posedge clock) begin
      if (cmd.prod_load) begin
         prod_ff <= PROD_W'(elapsed_p1) * PROD_W'(tempo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_tempo_ff <= TEMPO_W'(MIN_RESET);
         max_tempo_ff <= TEMPO_W'(MAX_RESET);
         tempo_ff     <= TEMPO_W'(TEMPO_RESET);
         click_ff     <= 1'b0;
         play_col_ff  <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == CSR_MIN_TEMPO) begin
            min_tempo_ff <= csr_wdata;
         end
         if (csr_write && csr_index == CSR_MAX_TEMPO) begin
            max_tempo_ff <= csr_wdata;
         end
         tempo_ff <= tempo_in;
         if (cmd.click_flip) begin
            click_ff <= ~click_ff;
         end
         if (cmd.elapsed_inc && elapsed_ff != '1) begin
            elapsed_ff <= elapsed_ff + ELAPSED_W'(1);
         end else if (cmd.step_begin) begin
            elapsed_ff <= '0;
         end
         if (cmd.load_rsp) begin
            play_col_ff <= (play_col_ff == ColW'(COLUMNS - 1)) ? '0
                                                                : play_col_ff + ColW'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_col_ff   <= STEP_W'(play_col_ff);
         rsp_mask_ff  <= MASK_W'(rd_eff);
         rsp_click_ff <= click_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_column = rsp_col_ff;
   assign rsp_note_mask   = rsp_mask_ff;
   assign rsp_click       = rsp_click_ff;

   always_comb begin
      status.action      = item_action_ff;
      status.toggle_ok   = (int'(item_col_ff) < COLUMNS) && (int'(item_row_ff) < ROWS);
      status.step_due    = (tempo_ff == '0) ? (elapsed_ff == '1)
                                            : (prod_ff > PROD_W'(BEAT_MS));
      status.hold_slower = item_slower_ff;
      status.hold_faster = item_faster_ff;
      status.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   // play position stays inside the grid
   assert property (@(posedge clock) disable iff (reset)
      int'(play_col_ff) < COLUMNS)
      else $error("play column outside grid");

   // the quotient never exceeds the tempo it was taken from
   assert property (@(posedge clock) disable iff (reset)
      cmd.tempo_down |-> quot_ff <= tempo_ff)
      else $error("tempo quotient larger than tempo");

   // a step restarts the elapsed count
   assert property (@(posedge clock) disable iff (reset)
      cmd.step_begin |=> elapsed_ff == '0)
      else $error("elapsed count not restarted on step");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the step sequencer tempo grid
// ---------------------------------------------------------------------------
// drives edit, nudge and millisecond tick items into the sequencer, mirrors
// the grid, tempo and elapsed counter on the bench side, and checks every
// step the block plays against the mirror, field by field and in order.
// tests run in turn: grid edits, step playback, tempo limits (zero tempo and
// crossed limits among them), a long random mix over several limit settings,
// and an output stall that backs the sequencer up
// ---------------------------------------------------------------------------

module tb_top;
   import sstg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS = COLUMNS_DEF;
   localparam int ROWS    = ROWS_DEF;

   localparam int unsigned ELAPSED_MAX = 2**ELAPSED_W - 1;
   localparam int unsigned CELL_MAX    = 2**CELL_W - 1;
   localparam int unsigned NUDGE_DIV   = 25;
   localparam int unsigned HOLD_DIV    = 10;
   localparam int unsigned TOP_TEMPO   = 1000;

   // action codes the block has no use for
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = ACT_FASTER + 3'd1;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = '1;

   localparam int SETTLE_CYCLES = 16;        // longest item plus margin
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 900;
   localparam int PHASE_ITEMS   = 150;
   localparam int STALL_CYCLES  = 800;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [CELL_W-1:0]   column;
      logic [CELL_W-1:0]   row;
      logic                slower;
      logic                faster;
   } seq_item_t;

   typedef struct packed {
      logic [STEP_W-1:0] column;
      logic [MASK_W-1:0] mask;
      logic              click;
   } step_t;

   // ports; the driven ones are all known from time zero
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ACTION_W-1:0]  req_action = ACT_TICK;
   logic [CELL_W-1:0]    req_cell_column = '0;
   logic [CELL_W-1:0]    req_cell_row = '0;
   logic                 req_hold_slower = 1'b0;
   logic                 req_hold_faster = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STEP_W-1:0]    rsp_step_column;
   logic [MASK_W-1:0]    rsp_note_mask;
   logic                 rsp_click;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MIN_TEMPO;
   logic [TEMPO_W-1:0]   csr_wdata = '0;

   // bench-side copy of the sequencer state
   logic [ROWS-1:0]    grid_mirror [COLUMNS];
   logic [TEMPO_W-1:0] tempo_mirror;
   logic [TEMPO_W-1:0] min_mirror;
   logic [TEMPO_W-1:0] max_mirror;
   logic               click_mirror;
   int unsigned        column_mirror;
   int unsigned        elapsed_mirror;
   int unsigned        steps_predicted = 0;

   step_t expected_steps[$];

   int  mismatches = 0;
   int  cycle_count = 0;
   bit  rsp_taken = 1'b0;
   bit  req_idle_on = 1'b1;     // sender gaps on or off
   bit  rsp_idle_on = 1'b1;     // receiver gaps on or off
   int  rsp_hold_req = 0;       // one long receiver hold-off, in cycles
   int  ready_wait = 0;

   step_sequencer_tempo_grid u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_cell_column (req_cell_column),
      .req_cell_row    (req_cell_row),
      .req_hold_slower (req_hold_slower),
      .req_hold_faster (req_hold_faster),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_step_column (rsp_step_column),
      .rsp_note_mask   (rsp_note_mask),
      .rsp_click       (rsp_click),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tempo mirror
   // ------------------------------------------------------------------------

   // decrease clamps only against the lower limit
   function automatic void lower_tempo(int unsigned divisor);
      int unsigned t;
      t = tempo_mirror;
      t = t - t / divisor;
      if (t < min_mirror)
         t = min_mirror;
      tempo_mirror = t[TEMPO_W-1:0];
   endfunction

   // increase clamps only against the upper limit
   function automatic void raise_tempo(int unsigned divisor);
      int unsigned t;
      t = tempo_mirror;
      t = t + t / divisor;
      if (t > max_mirror)
         t = max_mirror;
      tempo_mirror = t[TEMPO_W-1:0];
   endfunction

   function automatic void reset_mirror();
      foreach (grid_mirror[c])
         grid_mirror[c] = '0;
      tempo_mirror   = TEMPO_W'(TEMPO_RESET);
      min_mirror     = TEMPO_W'(MIN_RESET);
      max_mirror     = TEMPO_W'(MAX_RESET);
      click_mirror   = 1'b0;
      column_mirror  = 0;
      elapsed_mirror = 0;
   endfunction

   // apply one accepted item to the mirror, queue the step it plays if any
   function automatic void play_item(seq_item_t it);
      int unsigned period;
      step_t       s;
      case (it.action)
         ACT_TICK: begin
            if (elapsed_mirror < ELAPSED_MAX)
               elapsed_mirror++;
            // a zero tempo behaves like a divider answering all ones
            period = (tempo_mirror == 0) ? ELAPSED_MAX
                                         : int'(BEAT_MS) / int'(tempo_mirror);
            if (elapsed_mirror >= period) begin
               elapsed_mirror = 0;
               s.column = column_mirror[STEP_W-1:0];
               s.mask   = MASK_W'(grid_mirror[column_mirror]);
               s.click  = click_mirror;
               expected_steps.push_back(s);
               steps_predicted++;
               column_mirror = (column_mirror + 1 >= COLUMNS) ? 0 : column_mirror + 1;
               // slower first, then faster
               if (it.slower)
                  lower_tempo(HOLD_DIV);
               if (it.faster)
                  raise_tempo(HOLD_DIV);
            end
         end
         ACT_TOGGLE: begin
            // cells outside the grid are left alone
            if (it.column < COLUMNS && it.row < ROWS)
               grid_mirror[it.column][it.row] = ~grid_mirror[it.column][it.row];
         end
         ACT_CLICK:  click_mirror = ~click_mirror;
         ACT_SLOWER: lower_tempo(NUDGE_DIV);
         ACT_FASTER: raise_tempo(NUDGE_DIV);
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // step checker and receiver
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      step_t want;
      rsp_taken = !reset && rsp_valid && rsp_ready;
      if (rsp_taken) begin
         if (expected_steps.size() == 0) begin
            mismatches++;
            if (mismatches <= 20)
               $error("step played with none pending: column %0d mask %b click %0d",
                      rsp_step_column, rsp_note_mask, rsp_click);
         end else begin
            want = expected_steps.pop_front();
            if (rsp_step_column !== want.column) begin
               mismatches++;
               $error("step_column: expected %0d, got %0d", want.column, rsp_step_column);
            end
            if (rsp_note_mask !== want.mask) begin
               mismatches++;
               $error("note_mask: expected %b, got %b", want.mask, rsp_note_mask);
            end
            if (rsp_click !== want.click) begin
               mismatches++;
               $error("click: expected %0d, got %0d", want.click, rsp_click);
            end
         end
      end
   end

   // receiver: random wait after every step taken while gaps are on, or one long hold-off
   always @(negedge clock) begin
      if (rsp_hold_req != 0) begin
         ready_wait   = rsp_hold_req;
         rsp_hold_req = 0;
      end else if (rsp_taken) begin
         ready_wait = rsp_idle_on ? $urandom_range(0, 15) : 0;
      end
      if (ready_wait > 0) begin
         rsp_ready <= 1'b0;
         ready_wait--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // item sender and helpers
   // ------------------------------------------------------------------------

   // optional gap, then offer the item until the sequencer takes it
   task automatic send_item(seq_item_t it);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= it.action;
      req_cell_column <= it.column;
      req_cell_row    <= it.row;
      req_hold_slower <= it.slower;
      req_hold_faster <= it.faster;
      do @(posedge clock); while (!req_ready);
      play_item(it);
   endtask

   // cell coordinates are random, they only matter on a toggle
   function automatic seq_item_t make_item(logic [ACTION_W-1:0] action,
                                           logic slower, logic faster);
      seq_item_t it;
      it.action = action;
      it.column = CELL_W'($urandom_range(0, CELL_MAX));
      it.row    = CELL_W'($urandom_range(0, CELL_MAX));
      it.slower = slower;
      it.faster = faster;
      return it;
   endfunction

   task automatic send_toggle(int unsigned column, int unsigned row);
      seq_item_t it;
      it = make_item(ACT_TOGGLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      it.column = CELL_W'(column);
      it.row    = CELL_W'(row);
      send_item(it);
   endtask

   // drop valid and wait until every queued step has been read
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [CSR_IDX_W-1:0] idx, logic [TEMPO_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_MIN_TEMPO)
         min_mirror = value;
      else
         max_mirror = value;
   endtask

   task automatic set_limits(int unsigned lo, int unsigned hi);
      wait_idle();
      write_limit(CSR_MIN_TEMPO, TEMPO_W'(lo));
      write_limit(CSR_MAX_TEMPO, TEMPO_W'(hi));
   endtask

   // slower then faster lands the tempo inside ordered limits
   task automatic settle_tempo();
      send_item(make_item(ACT_SLOWER, 1'b0, 1'b0));
      send_item(make_item(ACT_FASTER, 1'b0, 1'b0));
   endtask

   task automatic tick_until_steps(int unsigned n, logic slower, logic faster);
      int unsigned goal;
      goal = steps_predicted + n;
      while (steps_predicted < goal)
         send_item(make_item(ACT_TICK, slower, faster));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // corner cells, out-of-grid rows, click, nudges and unused codes
   task automatic test_grid_edits();
      seq_item_t it;
      send_toggle(0, 0);
      send_toggle(CELL_MAX, ROWS - 1);
      send_toggle(CELL_MAX, 0);
      send_toggle(0, ROWS - 1);
      send_toggle(7, 4);
      send_toggle(7, 4);            // flips back off
      send_toggle(7, 4);
      send_toggle(3, ROWS);         // first row past the grid
      send_toggle(12, CELL_MAX);    // last row code, also outside
      send_item(make_item(ACT_CLICK, 1'b1, 1'b1));
      send_item(make_item(ACT_CLICK, 1'b0, 1'b0));
      send_item(make_item(ACT_CLICK, 1'b1, 1'b0));
      send_item(make_item(ACT_SLOWER, 1'b1, 1'b1));
      send_item(make_item(ACT_FASTER, 1'b0, 1'b1));
      for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++) begin
         it = make_item(ACTION_W'(a), 1'b1, 1'b1);
         it.column = CELL_MAX;
         it.row    = 0;
         send_item(it);
      end
      // hold flags on a tick that does not step
      send_item(make_item(ACT_TICK, 1'b1, 1'b1));
   endtask

   // tempo held at 1000 so steps come every 60 ticks
   task automatic test_step_playback();
      set_limits(TOP_TEMPO, TOP_TEMPO);
      settle_tempo();
      tick_until_steps(3, 1'b0, 1'b0);
   endtask

   task automatic test_tempo_limits();
      // lowest nonzero tempo
      set_limits(1, 1);
      settle_tempo();
      repeat (3) send_item(make_item(ACT_TICK, 1'b1, 1'b1));
      // zero upper limit drives the tempo to zero
      wait_idle();
      write_limit(CSR_MAX_TEMPO, '0);
      send_item(make_item(ACT_FASTER, 1'b0, 1'b0));
      repeat (3) send_item(make_item(ACT_TICK, 1'b0, 1'b0));
      send_item(make_item(ACT_SLOWER, 1'b0, 1'b0));
      wait_idle();
      write_limit(CSR_MIN_TEMPO, '0);
      send_item(make_item(ACT_SLOWER, 1'b0, 1'b0));
      // crossed limits: decrease jumps up to min, increase drops to max
      set_limits(TOP_TEMPO, 1);
      send_item(make_item(ACT_SLOWER, 1'b0, 1'b0));
      tick_until_steps(1, 1'b1, 1'b1);
      send_item(make_item(ACT_FASTER, 1'b0, 1'b0));
      send_item(make_item(ACT_SLOWER, 1'b0, 1'b0));
      tick_until_steps(1, 1'b0, 1'b1);
   endtask

   // mostly ticks with random holds, limits kept high so steps come often
   function automatic seq_item_t random_item();
      seq_item_t   it;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      it   = make_item(ACT_TICK, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      if (pick >= 97)
         it.action = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      else if (pick >= 95)
         it.action = ACT_FASTER;
      else if (pick >= 93)
         it.action = ACT_SLOWER;
      else if (pick >= 91)
         it.action = ACT_CLICK;
      else if (pick >= 86)
         it.action = ACT_TOGGLE;
      return it;
   endfunction

   task automatic test_random_mix();
      int unsigned counted;
      int unsigned phase;
      int unsigned lo;
      int unsigned hi;
      seq_item_t   it;
      counted   = 0;
      phase     = 0;
      while (counted < RANDOM_ITEMS) begin
         case (phase % 6)
            0:       begin lo = 900;       hi = TOP_TEMPO; end
            1:       begin lo = 500;       hi = TOP_TEMPO; end
            2:       begin lo = 850;       hi = 998;       end
            3:       begin lo = TOP_TEMPO; hi = TOP_TEMPO; end
            4:       begin lo = 700;       hi = 900;       end
            default: begin lo = 600;       hi = TOP_TEMPO; end
         endcase
         set_limits(lo, hi);
         // some phases run back to back with no gaps on one side or both
         req_idle_on = $urandom_range(0, 3) != 0;
         rsp_idle_on = $urandom_range(0, 3) != 0;
         settle_tempo();
         repeat (PHASE_ITEMS) begin
            it = random_item();
            send_item(it);
            counted++;
         end
         phase++;
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // receiver holds off while ticks keep coming, so the sequencer backs up
   task automatic test_output_stall();
      set_limits(TOP_TEMPO, TOP_TEMPO);
      settle_tempo();
      req_idle_on  = 1'b0;
      rsp_idle_on  = 1'b0;
      rsp_hold_req = STALL_CYCLES;
      repeat (400) send_item(make_item(ACT_TICK, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1))));
      // sender pauses until every step is out
      wait_idle();
      repeat (120) send_item(make_item(ACT_TICK, 1'b0, 1'b0));
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // sequence of tests
   // ------------------------------------------------------------------------

   initial begin
      reset_mirror();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_grid_edits();
      test_step_playback();
      test_tempo_limits();
      test_random_mix();
      test_output_stall();

      wait_idle();
      if (mismatches == 0 && expected_steps.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
design/sstg_pkg.sv
design/sstg_ctrl.sv
design/sstg_datapath.sv
design/step_sequencer_tempo_grid.sv
test/tb_top.sv
